FILE: src/ops_pkg.sv
// package for the output pattern sequencer: constants, command and entry types, states
`timescale 1ns / 1ps
`default_nettype none

package ops_pkg;

    localparam int CHANNEL_COUNT_DEF = 5;
    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CH_W     = 3;
    localparam int ADDR_W   = 6;
    localparam int MS_W     = 16;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 26;
    localparam int MASK_W   = 8;

    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = 16'd1000;
    localparam logic [9:0]          MS_TO_US          = 10'd1000;

    localparam logic [1:0] OPC_WRITE = 2'd0;
    localparam logic [1:0] OPC_START = 2'd1;
    localparam logic [1:0] OPC_TICK  = 2'd2;

    localparam logic [1:0] KIND_TIMED = 2'd0;
    localparam logic [1:0] KIND_LOOP  = 2'd1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_START,
        OP_TICK,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [MS_W-1:0] ms;
        logic [1:0]      kind;
        logic            level;
    } t_entry;

    typedef struct packed {
        t_op               op;
        logic [CH_W-1:0]   ch;
        logic [ADDR_W-1:0] addr;
        t_entry            entry;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENTER_RD,
        S_ENTER_USE,
        S_TICK_CH,
        S_TICK_USE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_NEXT,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

FILE: src/ops_if.sv
// channel interfaces: command in, result out, configuration write
`timescale 1ns / 1ps
`default_nettype none

interface ops_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  channel;
    logic [5:0]  entry_address;
    logic        entry_level;
    logic [1:0]  entry_kind;
    logic [15:0] entry_duration_ms;

    modport source (output valid, opcode, channel, entry_address, entry_level,
                    entry_kind, entry_duration_ms, input ready);
    modport sink (input valid, opcode, channel, entry_address, entry_level,
                  entry_kind, entry_duration_ms, output ready);
endinterface

interface ops_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] output_levels;
    logic [7:0] running_mask;

    modport source (output valid, output_levels, running_mask, input ready);
    modport sink (input valid, output_levels, running_mask, output ready);
endinterface

interface ops_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] tick_period_us;

    modport source (output valid, tick_period_us, input ready);
    modport sink (input valid, tick_period_us, output ready);
endinterface

`default_nettype wire

FILE: src/ops_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ops_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/ops_front.sv
// command front end: accepts and classifies commands into a short queue
`timescale 1ns / 1ps
`default_nettype none

module ops_front import ops_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ops_cmd_if.sink    i_cmd,
    output      logic  o_q_valid,
    output      t_cmd  o_q_cmd,
    input  wire logic  i_q_pop
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [QCW-1:0] r_count, n_count;
    logic [QPW-1:0] r_wr_ptr, r_rd_ptr;
    t_cmd           r_q [QUEUE_DEPTH];
    t_cmd           cls;
    logic           push;

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] w;
        w = a;
        for (int k = 1; k * PATTERN_DEPTH < (1 << ADDR_W); k++) begin
            if (a >= ADDR_W'(k * PATTERN_DEPTH)) begin
                w = a - ADDR_W'(k * PATTERN_DEPTH);
            end
        end
        return w;
    endfunction

    always_comb begin
        cls.ch          = i_cmd.channel;
        cls.addr        = wrap_addr(i_cmd.entry_address);
        cls.entry.level = i_cmd.entry_level;
        cls.entry.kind  = i_cmd.entry_kind;
        cls.entry.ms    = i_cmd.entry_duration_ms;
        unique case (i_cmd.opcode)
            OPC_WRITE: cls.op = OP_WRITE;
            OPC_START: begin
                cls.op = ({1'b0, i_cmd.channel} < (CH_W + 1)'(CHANNEL_COUNT)) ? OP_START
                                                                              : OP_NOP;
            end
            OPC_TICK:  cls.op = OP_TICK;
            default:   cls.op = OP_NOP;
        endcase
    end

    assign i_cmd.ready = (r_count != QCW'(QUEUE_DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_q_valid   = (r_count != '0);
    assign o_q_cmd     = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({push, i_q_pop})
            2'b10:   n_count = r_count + QCW'(1);
            2'b01:   n_count = r_count - QCW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPW'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

FILE: src/ops_div.sv
// restoring divider, one quotient bit per cycle, zero divisor taken as one
`timescale 1ns / 1ps
`default_nettype none

module ops_div import ops_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [COUNT_W-1:0]  i_dividend,
    input  wire logic [PERIOD_W-1:0] i_divisor,
    output      logic                o_done,
    output      logic [COUNT_W-1:0]  o_quotient
);

    localparam int SCW = $clog2(COUNT_W);

    logic                r_busy;
    logic                r_done;
    logic [SCW-1:0]      r_step;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_div;
    logic [COUNT_W-1:0]  r_quo;
    logic [PERIOD_W:0]   shifted;
    logic [PERIOD_W+1:0] diff;

    assign shifted    = {r_rem, r_quo[COUNT_W-1]};
    assign diff       = {1'b0, shifted} - {2'b00, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SCW'(1);
                if (r_step == SCW'(COUNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= (i_divisor == '0) ? PERIOD_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= diff[PERIOD_W+1] ? shifted[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
            r_quo <= {r_quo[COUNT_W-2:0], ~diff[PERIOD_W+1]};
        end
    end

endmodule

`default_nettype wire

FILE: src/ops_back.sv
// execution back end: pattern store, channel state, sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

module ops_back import ops_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  wire t_cmd                i_q_cmd,
    output      logic                o_q_pop,
    input  wire logic [PERIOD_W-1:0] i_tick_period_us,
    ops_res_if.source                o_res
);

    localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int AW = $clog2(PATTERN_DEPTH);

    t_state r_state, n_state;

    logic [CHANNEL_COUNT-1:0] r_level;
    logic [CHANNEL_COUNT-1:0] r_active;
    logic [AW-1:0]            r_start [CHANNEL_COUNT];
    logic [AW-1:0]            r_next  [CHANNEL_COUNT];
    logic [COUNT_W-1:0]       r_count [CHANNEL_COUNT];

    logic [CW-1:0]      r_ch;
    logic [AW-1:0]      r_sa;
    logic               r_is_tick;
    logic [MS_W-1:0]    r_ms;
    logic [COUNT_W-1:0] r_prod;

    logic               r_out_valid;
    logic [MASK_W-1:0]  r_levels;
    logic [MASK_W-1:0]  r_running;

    logic [CW-1:0]      cmd_ch;
    logic [AW-1:0]      cmd_addr;
    logic               start_skip;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    t_entry             rd_entry;
    logic               div_start;
    logic               div_done;
    logic [COUNT_W-1:0] div_quo;
    logic               out_free;
    logic               out_load;
    logic               last_ch;
    logic               expire;
    logic [MASK_W-1:0]  levels_now;
    logic [MASK_W-1:0]  running_now;

    function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
        logic [AW:0] s;
        s = {1'b0, a} + (AW + 1)'(1);
        return (s == (AW + 1)'(PATTERN_DEPTH)) ? '0 : s[AW-1:0];
    endfunction

    ops_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(PATTERN_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(cmd_addr),
        .i_wdata(i_q_cmd.entry),
        .i_raddr(ram_raddr),
        .o_rdata(rd_entry)
    );

    ops_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_prod),
        .i_divisor (i_tick_period_us),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    assign cmd_ch     = i_q_cmd.ch[CW-1:0];
    assign cmd_addr   = i_q_cmd.addr[AW-1:0];
    assign start_skip = r_active[cmd_ch] && (r_start[cmd_ch] == cmd_addr);
    assign out_free   = !r_out_valid || o_res.ready;
    assign last_ch    = (r_ch == CW'(CHANNEL_COUNT - 1));
    assign expire     = (r_count[r_ch] == COUNT_W'(1));

    always_comb begin
        levels_now  = '0;
        running_now = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            levels_now[i]  = r_level[i];
            running_now[i] = r_active[i] && (r_count[i] != '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_START: n_state = start_skip ? S_RESULT : S_ENTER_RD;
                        OP_TICK:  n_state = S_TICK_CH;
                        default:  n_state = S_RESULT;
                    endcase
                end
            end
            S_ENTER_RD:  n_state = S_ENTER_USE;
            S_ENTER_USE: begin
                if (rd_entry.kind == KIND_TIMED) begin
                    n_state = S_MUL;
                end else begin
                    n_state = r_is_tick ? S_NEXT : S_RESULT;
                end
            end
            S_TICK_CH:   n_state = (expire && r_active[r_ch]) ? S_TICK_USE : S_NEXT;
            S_TICK_USE: begin
                if (rd_entry.kind == KIND_TIMED) begin
                    n_state = S_MUL;
                end else if (rd_entry.kind == KIND_LOOP) begin
                    n_state = S_ENTER_RD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MUL:       n_state = S_DIV_GO;
            S_DIV_GO:    n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = r_is_tick ? S_NEXT : S_RESULT;
                end
            end
            S_NEXT:      n_state = last_ch ? S_RESULT : S_TICK_CH;
            S_RESULT:    n_state = out_free ? S_IDLE : S_RESULT;
            default:     n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop   = (r_state == S_IDLE) && i_q_valid;
        ram_we    = o_q_pop && (i_q_cmd.op == OP_WRITE);
        ram_raddr = (r_state == S_TICK_CH) ? r_next[r_ch] : r_sa;
        div_start = (r_state == S_DIV_GO);
        out_load  = (r_state == S_RESULT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            r_is_tick   <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_start[i] <= '0;
                r_next[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ch      <= (i_q_cmd.op == OP_TICK) ? '0 : cmd_ch;
                        r_is_tick <= (i_q_cmd.op == OP_TICK);
                    end
                end
                S_ENTER_USE: begin
                    r_start[r_ch] <= r_sa;
                    r_level[r_ch] <= rd_entry.level;
                    r_next[r_ch]  <= inc_addr(r_sa);
                    if (rd_entry.kind == KIND_TIMED) begin
                        r_active[r_ch] <= 1'b1;
                    end else begin
                        r_active[r_ch] <= 1'b0;
                        r_count[r_ch]  <= '0;
                    end
                end
                S_TICK_CH: begin
                    if (r_count[r_ch] != '0) begin
                        r_count[r_ch] <= r_count[r_ch] - COUNT_W'(1);
                        if (expire && !r_active[r_ch]) begin
                            r_level[r_ch] <= 1'b0;
                        end
                    end
                end
                S_TICK_USE: begin
                    r_next[r_ch] <= inc_addr(r_next[r_ch]);
                    if (rd_entry.kind == KIND_TIMED) begin
                        r_level[r_ch] <= rd_entry.level;
                    end else if (rd_entry.kind != KIND_LOOP) begin
                        r_level[r_ch]  <= rd_entry.level;
                        r_count[r_ch]  <= '0;
                        r_active[r_ch] <= 1'b0;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_count[r_ch] <= div_quo;
                    end
                end
                S_NEXT: begin
                    if (!last_ch) begin
                        r_ch <= r_ch + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_sa <= cmd_addr;
        end else if (r_state == S_TICK_USE) begin
            r_sa <= r_start[r_ch];
        end
        if (r_state == S_ENTER_USE || r_state == S_TICK_USE) begin
            r_ms <= rd_entry.ms;
        end
        if (r_state == S_MUL) begin
            r_prod <= COUNT_W'(r_ms) * COUNT_W'(MS_TO_US);
        end
        if (out_load) begin
            r_levels  <= levels_now;
            r_running <= running_now;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.output_levels = r_levels;
    assign o_res.running_mask  = r_running;

endmodule

`default_nettype wire

FILE: src/output_pattern_sequencer_core.sv
// top level of the output pattern sequencer
//
//   port    dir   role
//   i_cmd   in    write entry, start channel, tick (one transfer per command)
//   o_res   out   output_levels and running_mask, one transfer per command
//   i_cfg   in    tick_period_us write, always ready
//
// a command waits in the queue until the sequencer is idle; a write or skipped start then goes straight to the result
// a start reads its first entry; a timed entry then goes through the multiply and the 26-step divider
// a tick visits each channel in turn and loads the next entry of each active channel whose count expires
// a two-entry command queue lets i_cmd take up to two commands while the sequencer works
// the result register holds until taken; the sequencer waits on it, not the queue
// synchronous active-low reset clears channel state; the pattern store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module output_pattern_sequencer_core import ops_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ops_cmd_if.sink   i_cmd,
    ops_res_if.source o_res,
    ops_cfg_if.sink   i_cfg
);

    logic [PERIOD_W-1:0] r_tick_period_us;
    logic                q_valid;
    t_cmd                q_cmd;
    logic                q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period_us <= TICK_PERIOD_RESET;
        end else if (i_cfg.valid) begin
            r_tick_period_us <= i_cfg.tick_period_us;
        end
    end

    ops_front #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .PATTERN_DEPTH(PATTERN_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .o_q_valid(q_valid),
        .o_q_cmd  (q_cmd),
        .i_q_pop  (q_pop)
    );

    ops_back #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .PATTERN_DEPTH(PATTERN_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .i_tick_period_us(r_tick_period_us),
        .o_res           (o_res)
    );

endmodule

`default_nettype wire

FILE: tb/output_pattern_sequencer_core_tb.sv
// testbench for output_pattern_sequencer_core: directed and random commands against a predictor
`timescale 1ns / 1ps

module output_pattern_sequencer_core_tb;
    import ops_pkg::*;

    localparam logic [1:0] KIND_HALT     = 2'd2;
    localparam logic [1:0] KIND_HALT_ALT = 2'd3;
    localparam int PHASE_ITEMS    = 250;
    localparam int PHASE_COUNT    = 7;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_HOLD_OFF = 250;
    localparam int PRINT_LIMIT    = 40;

    typedef enum logic [1:0] {
        ST_CMD,
        ST_CFG,
        ST_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind          what;
        t_op                 op;
        logic [CH_W-1:0]     ch;
        logic [ADDR_W-1:0]   addr;
        t_entry              ent;
        logic [PERIOD_W-1:0] period;
    } t_stim;

    typedef struct packed {
        logic [MASK_W-1:0] levels;
        logic [MASK_W-1:0] running;
    } t_pins;

    logic clk;
    logic rst_n;

    ops_cmd_if cmd_bus ();
    ops_res_if res_bus ();
    ops_cfg_if cfg_bus ();

    output_pattern_sequencer_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    t_stim stim_q[$];
    t_pins levels_due_q[$];

    // predictor state
    t_entry              store_m [PATTERN_DEPTH_DEF] = '{default: '0};
    logic                seq_level  [CHANNEL_COUNT_DEF] = '{default: 1'b0};
    logic                seq_active [CHANNEL_COUNT_DEF] = '{default: 1'b0};
    logic [ADDR_W-1:0]   seq_start  [CHANNEL_COUNT_DEF] = '{default: '0};
    logic [ADDR_W-1:0]   seq_next   [CHANNEL_COUNT_DEF] = '{default: '0};
    logic [COUNT_W-1:0]  seq_count  [CHANNEL_COUNT_DEF] = '{default: '0};
    logic [PERIOD_W-1:0] period_m = TICK_PERIOD_RESET;

    int cmd_issued   = 0;
    int cmd_taken    = 0;
    int cfg_issued   = 0;
    int cfg_taken    = 0;
    int result_count = 0;
    int fail_count   = 0;
    int quiet_cycles = 0;
    int send_gap     = 0;
    int hold_left    = 0;
    bit calm         = 1'b0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic log_error(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) $display("ERROR result %0d: %s", result_count, msg);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COUNT_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        logic [31:0] div;
        logic [31:0] prod;
        div  = (period_m == '0) ? 32'd1 : {16'd0, period_m};
        prod = ms * MS_TO_US;
        return COUNT_W'(prod / div);
    endfunction

    task automatic enter_pattern_at(input int ch, input logic [ADDR_W-1:0] a);
        t_entry e;
        e = store_m[a];
        seq_start[ch] = a;
        seq_level[ch] = e.level;
        seq_next[ch]  = a + 1'b1;
        if (e.kind == KIND_TIMED) begin
            seq_active[ch] = 1'b1;
            seq_count[ch]  = ms_to_ticks(e.ms);
        end else begin
            seq_active[ch] = 1'b0;
            seq_count[ch]  = '0;
        end
    endtask

    task automatic advance_pattern(input int ch);
        t_entry e;
        if (seq_count[ch] == '0) return;
        seq_count[ch] = seq_count[ch] - 1'b1;
        if (seq_count[ch] != '0) return;
        if (!seq_active[ch]) begin
            seq_level[ch] = 1'b0;
            return;
        end
        e = store_m[seq_next[ch]];
        seq_next[ch] = seq_next[ch] + 1'b1;
        if (e.kind == KIND_TIMED) begin
            seq_level[ch] = e.level;
            seq_count[ch] = ms_to_ticks(e.ms);
        end else if (e.kind == KIND_LOOP) begin
            enter_pattern_at(ch, seq_start[ch]);
        end else begin
            seq_level[ch]  = e.level;
            seq_count[ch]  = '0;
            seq_active[ch] = 1'b0;
        end
    endtask

    task automatic apply_command(input t_op op, input logic [CH_W-1:0] ch,
                                 input logic [ADDR_W-1:0] addr, input t_entry ent);
        t_pins pins;
        case (op)
            OP_WRITE: begin
                store_m[addr] = ent;
            end
            OP_START: begin
                if (ch < CHANNEL_COUNT_DEF && !(seq_active[ch] && seq_start[ch] == addr))
                    enter_pattern_at(ch, addr);
            end
            OP_TICK: begin
                for (int i = 0; i < CHANNEL_COUNT_DEF; i++) advance_pattern(i);
            end
            default: ;
        endcase
        pins = '0;
        for (int i = 0; i < CHANNEL_COUNT_DEF; i++) begin
            pins.levels[i]  = seq_level[i];
            pins.running[i] = seq_active[i] && (seq_count[i] != '0);
        end
        levels_due_q.push_back(pins);
    endtask

    // stimulus construction
    function automatic void push_cmd(input t_op op, input logic [CH_W-1:0] ch,
                                     input logic [ADDR_W-1:0] addr, input logic lvl,
                                     input logic [1:0] kind, input logic [MS_W-1:0] ms);
        t_stim s;
        s.what   = ST_CMD;
        s.op     = op;
        s.ch     = ch;
        s.addr   = addr;
        s.ent    = '{ms: ms, kind: kind, level: lvl};
        s.period = '0;
        stim_q.push_back(s);
    endfunction

    function automatic void push_ctrl(input t_stim_kind what, input logic [PERIOD_W-1:0] period);
        t_stim s;
        s.what   = what;
        s.op     = OP_NOP;
        s.ch     = '0;
        s.addr   = '0;
        s.ent    = '0;
        s.period = period;
        stim_q.push_back(s);
    endfunction

    function automatic logic [MS_W-1:0] pick_ms(input int unsigned period);
        int unsigned pe;
        int unsigned v;
        pe = (period == 0) ? 1 : period;
        if ($urandom_range(0, 24) == 0) return MS_W'($urandom);
        v = ($urandom_range(0, 5) * pe) / 1000 + $urandom_range(0, 1);
        if (v > 65535) v = 65535;
        return MS_W'(v);
    endfunction

    function automatic void push_tick();
        push_cmd(OP_TICK, CH_W'($urandom), ADDR_W'($urandom), 1'($urandom), 2'($urandom),
                 MS_W'($urandom));
    endfunction

    function automatic int push_random_group(input int unsigned period);
        int r;
        int n;
        logic [ADDR_W-1:0] base;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            base = ADDR_W'($urandom);
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                push_cmd(OP_WRITE, CH_W'($urandom), base + ADDR_W'(k), 1'($urandom),
                         KIND_TIMED, pick_ms(period));
            push_cmd(OP_WRITE, CH_W'($urandom), base + ADDR_W'(n), 1'($urandom),
                     2'($urandom_range(KIND_LOOP, KIND_HALT_ALT)), pick_ms(period));
            r = $urandom_range(1, 3);
            for (int k = 0; k < r; k++)
                push_cmd(OP_START, CH_W'($urandom_range(0, CHANNEL_COUNT_DEF - 1)), base,
                         1'($urandom), 2'($urandom), MS_W'($urandom));
            n = n + 1 + r;
            r = $urandom_range(2, 10);
            for (int k = 0; k < r; k++) push_tick();
            return n + r;
        end
        if (r < 70) begin
            push_tick();
        end else if (r < 82) begin
            push_cmd(OP_START, CH_W'($urandom), ADDR_W'($urandom), 1'($urandom),
                     2'($urandom), MS_W'($urandom));
        end else if (r < 94) begin
            push_cmd(OP_WRITE, CH_W'($urandom), ADDR_W'($urandom), 1'($urandom),
                     2'($urandom), pick_ms(period));
        end else if (r < 97) begin
            push_cmd(OP_NOP, CH_W'($urandom), ADDR_W'($urandom), 1'($urandom),
                     2'($urandom), MS_W'($urandom));
        end else begin
            push_ctrl(ST_DRAIN, '0);
            push_tick();
        end
        return 1;
    endfunction

    task automatic build_stimulus();
        int order [PATTERN_DEPTH_DEF];
        int j;
        int t;
        int made;
        int unsigned period;
        int unsigned plan [PHASE_COUNT] = '{1000, 1, 65535, 0, 250, 0, 1000};

        // small patterns: loop with wrap from the top entry, stop, kind three, zero duration
        push_cmd(OP_WRITE, 0, 0,  1'b1, KIND_TIMED,    2);
        push_cmd(OP_WRITE, 0, 1,  1'b0, KIND_TIMED,    1);
        push_cmd(OP_WRITE, 0, 2,  1'b0, KIND_LOOP,     16'hFFFF);
        push_cmd(OP_WRITE, 0, 63, 1'b0, KIND_TIMED,    1);
        push_cmd(OP_WRITE, 0, 3,  1'b1, KIND_HALT,     0);
        push_cmd(OP_WRITE, 0, 4,  1'b0, KIND_TIMED,    0);
        push_cmd(OP_WRITE, 0, 5,  1'b1, KIND_TIMED,    1);
        push_cmd(OP_WRITE, 0, 6,  1'b1, KIND_HALT_ALT, 0);
        push_cmd(OP_START, 0, 0,  1'b0, KIND_TIMED,    0);
        push_cmd(OP_START, 0, 0,  1'b1, KIND_LOOP,     0);
        push_cmd(OP_START, 1, 63, 1'b0, KIND_TIMED,    0);
        push_cmd(OP_START, 2, 3,  1'b0, KIND_TIMED,    0);
        push_cmd(OP_START, 3, 4,  1'b0, KIND_TIMED,    0);
        push_cmd(OP_START, 4, 5,  1'b0, KIND_TIMED,    0);
        push_cmd(OP_START, 7, 0,  1'b0, KIND_TIMED,    0);
        push_cmd(OP_START, 5, 3,  1'b0, KIND_TIMED,    0);
        for (int k = 0; k < 7; k++) push_tick();
        push_cmd(OP_NOP,   6, 63, 1'b1, KIND_HALT_ALT, 16'hFFFF);
        push_cmd(OP_START, 3, 2,  1'b0, KIND_TIMED,    0);
        push_ctrl(ST_DRAIN, '0);

        // fill the whole store before any further tick so no walk meets an empty entry
        for (int k = 0; k < PATTERN_DEPTH_DEF; k++) order[k] = k;
        for (int k = PATTERN_DEPTH_DEF - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < PATTERN_DEPTH_DEF; k++)
            push_cmd(OP_WRITE, CH_W'($urandom), ADDR_W'(order[k]), 1'($urandom),
                     ($urandom_range(0, 9) < 7) ? KIND_TIMED : 2'($urandom_range(1, 3)),
                     pick_ms(TICK_PERIOD_RESET));

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            period = plan[ph];
            if (ph == 5) period = $urandom_range(2, 65534);
            if (ph > 0) push_ctrl(ST_CFG, PERIOD_W'(period));
            made = 0;
            while (made < PHASE_ITEMS) made += push_random_group(period);
        end
    endtask

    // driver
    always @(negedge clk) begin
        t_stim s;
        logic nxt_cmd_v;
        logic nxt_cfg_v;
        logic nxt_ready;
        nxt_cmd_v = cmd_bus.valid;
        nxt_cfg_v = cfg_bus.valid;
        nxt_ready = res_bus.ready;
        if (rst_n) begin
            if (cmd_bus.valid && cmd_taken == cmd_issued) nxt_cmd_v = 1'b0;
            if (cfg_bus.valid && cfg_taken == cfg_issued) nxt_cfg_v = 1'b0;
            if (!nxt_cmd_v && !nxt_cfg_v && stim_q.size() != 0) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else begin
                    s = stim_q[0];
                    case (s.what)
                        ST_CMD: begin
                            cmd_bus.opcode            <= s.op;
                            cmd_bus.channel           <= s.ch;
                            cmd_bus.entry_address     <= s.addr;
                            cmd_bus.entry_level       <= s.ent.level;
                            cmd_bus.entry_kind        <= s.ent.kind;
                            cmd_bus.entry_duration_ms <= s.ent.ms;
                            nxt_cmd_v = 1'b1;
                            cmd_issued++;
                            send_gap = pick_gap();
                            void'(stim_q.pop_front());
                        end
                        ST_CFG: begin
                            if (levels_due_q.size() == 0) begin
                                cfg_bus.tick_period_us <= s.period;
                                nxt_cfg_v = 1'b1;
                                cfg_issued++;
                                void'(stim_q.pop_front());
                            end
                        end
                        default: begin
                            if (levels_due_q.size() == 0) void'(stim_q.pop_front());
                        end
                    endcase
                end
            end
            if (hold_left != 0) begin
                nxt_ready = 1'b0;
                hold_left--;
            end else begin
                nxt_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
            end
            if ($urandom_range(0, 63) == 0) calm = !calm;
        end
        cmd_bus.valid <= nxt_cmd_v;
        cfg_bus.valid <= nxt_cfg_v;
        res_bus.ready <= nxt_ready;
    end

    // monitor and scoreboard
    always @(posedge clk) begin
        t_pins want;
        t_entry ent;
        bit moved;
        if (rst_n) begin
            moved = 1'b0;
            if (res_bus.valid && res_bus.ready) begin
                moved = 1'b1;
                result_count++;
                if (levels_due_q.size() == 0) begin
                    log_error($sformatf("unexpected transfer levels %02h running %02h",
                                        res_bus.output_levels, res_bus.running_mask));
                end else begin
                    want = levels_due_q.pop_front();
                    if (res_bus.output_levels !== want.levels)
                        log_error($sformatf("output_levels %02h expected %02h",
                                            res_bus.output_levels, want.levels));
                    if (res_bus.running_mask !== want.running)
                        log_error($sformatf("running_mask %02h expected %02h",
                                            res_bus.running_mask, want.running));
                end
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                moved = 1'b1;
                cmd_taken++;
                ent = '{ms: cmd_bus.entry_duration_ms, kind: cmd_bus.entry_kind,
                        level: cmd_bus.entry_level};
                apply_command(t_op'(cmd_bus.opcode), cmd_bus.channel, cmd_bus.entry_address,
                              ent);
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved = 1'b1;
                cfg_taken++;
                period_m = cfg_bus.tick_period_us;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        rst_n                     = 1'b0;
        cmd_bus.valid             = 1'b0;
        cmd_bus.opcode            = '0;
        cmd_bus.channel           = '0;
        cmd_bus.entry_address     = '0;
        cmd_bus.entry_level       = 1'b0;
        cmd_bus.entry_kind        = '0;
        cmd_bus.entry_duration_ms = '0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.tick_period_us    = TICK_PERIOD_RESET;
        res_bus.ready             = 1'b0;
        build_stimulus();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_q.size() == 0 && !cmd_bus.valid && !cfg_bus.valid
              && levels_due_q.size() == 0);
        repeat (DRAIN_HOLD_OFF) @(posedge clk);
        if (levels_due_q.size() != 0)
            log_error($sformatf("%0d transfers never arrived", levels_due_q.size()));
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
